/* sv/lesq_pkg.sv */
// Shared definitions for the largest empty square scan block.
// Holds field widths, reset values, register indexes and the score helper.
// No dependencies.
`default_nettype none

package lesq_pkg;

  // Default grid limits, handed to the top level's parameters
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;

  // Fixed field widths
  localparam int unsigned CharW     = 8;
  localparam int unsigned ScoreW    = 11;
  localparam int unsigned RowWidthW = 11;
  localparam int unsigned PosOutW   = 10;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgObstacle = 1'b1;

  // Configuration reset values
  localparam logic [RowWidthW-1:0] RowWidthRst = 11'd1024;
  localparam logic [CharW-1:0]     ObstacleRst = 8'd111;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  // Per-cell classification passed from front to back
  typedef struct packed {
    logic blocked;  // cell equals the obstacle byte
    logic border;   // first row or first column
    logic last;     // final cell of the grid
    logic ovf;      // row overflow seen before this cell
  } lesq_flags_t;

  // Smallest of three scores
  function automatic logic [ScoreW-1:0] min3(input logic [ScoreW-1:0] a,
                                             input logic [ScoreW-1:0] b,
                                             input logic [ScoreW-1:0] c);
    logic [ScoreW-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/lesq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Contents are not reset. No dependencies.
`default_nettype none

module lesq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port, and read port that returns the old word on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/lesq_front.sv */
// Front part of the largest empty square scan: configuration registers,
// column and row tracking, and classification of each accepted cell.
// Depends on lesq_pkg.
`default_nettype none

module lesq_front #(
  parameter int unsigned MaxCols = lesq_pkg::MaxColsDef,
  parameter int unsigned MaxRows = lesq_pkg::MaxRowsDef,
  localparam int unsigned ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [lesq_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lesq_pkg::CfgDataW-1:0]    cfg_data_i,
  // cell stream
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lesq_pkg::CharW-1:0]       cell_char_i,
  input  logic                             last_cell_i,
  // classified cell toward the queue
  output logic                             push_o,
  input  logic                             push_ready_i,
  output logic [ColW-1:0]                  col_o,
  output logic [RowW-1:0]                  row_o,
  output lesq_pkg::lesq_flags_t            flags_o
);
  import lesq_pkg::*;

  localparam int unsigned WideW = (ColW + 1 > RowWidthW) ? ColW + 1 : RowWidthW;

  logic [RowWidthW-1:0] row_width_q;
  logic [CharW-1:0]     obstacle_q;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic                 ovf_q, ovf_d;

  logic [WideW-1:0] wide_rw;
  logic [WideW-1:0] eff_w;
  logic [ColW-1:0]  x;
  logic             row_end;
  logic             row_at_max;
  logic             accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthRst;
      obstacle_q  <= ObstacleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRowWidth: row_width_q <= cfg_data_i[RowWidthW-1:0];
        CfgObstacle: obstacle_q  <= cfg_data_i[CharW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the row width into one to MaxCols
  assign wide_rw = WideW'(row_width_q);
  always_comb begin
    if (row_width_q == '0) begin
      eff_w = WideW'(1);
    end else if (wide_rw > WideW'(MaxCols)) begin
      eff_w = WideW'(MaxCols);
    end else begin
      eff_w = wide_rw;
    end
  end

  // Wrap a column that lies beyond the current width
  assign x          = (WideW'(col_q) >= eff_w) ? '0 : col_q;
  assign row_end    = (WideW'(x) + WideW'(1)) >= eff_w;
  assign row_at_max = (row_q == RowW'(MaxRows - 1));

  // Pass the classified cell straight into the queue
  assign accept          = in_valid_i && push_ready_i;
  assign in_ready_o      = push_ready_i;
  assign push_o          = in_valid_i;
  assign col_o           = x;
  assign row_o           = row_q;
  assign flags_o.blocked = (cell_char_i == obstacle_q);
  assign flags_o.border  = (row_q == '0) || (x == '0);
  assign flags_o.last    = last_cell_i;
  assign flags_o.ovf     = ovf_q;

  // Advance position; clear on the last cell of a grid
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_cell_i) begin
        col_d = '0;
        row_d = '0;
        ovf_d = 1'b0;
      end else if (row_end) begin
        col_d = '0;
        if (row_at_max) begin
          ovf_d = 1'b1;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = x + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ovf_q <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  // A grid's last cell restarts the position at the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_cell_i) |=> (col_q == '0 && row_q == '0 && !ovf_q))
    else $error("position not cleared after last cell");

  // The stored column never leaves the line buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    WideW'(col_q) < WideW'(MaxCols))
    else $error("column index beyond line buffer");
`endif

endmodule

`default_nettype wire

/* sv/lesq_queue.sv */
// Two-entry queue between the front and back parts of the square scan.
// Generic payload width. Depends on nothing but its parameter.
`default_nettype none

module lesq_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/lesq_back.sv */
// Back part of the square scan: line buffer read, score, best tracking and
// the result register. Depends on lesq_pkg and lesq_ram.
`default_nettype none

module lesq_back #(
  parameter int unsigned MaxCols = lesq_pkg::MaxColsDef,
  parameter int unsigned MaxRows = lesq_pkg::MaxRowsDef,
  localparam int unsigned ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // classified cell from the queue
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  logic [ColW-1:0]                 q_col_i,
  input  logic [RowW-1:0]                 q_row_i,
  input  lesq_pkg::lesq_flags_t           q_flags_i,
  // result
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lesq_pkg::ScoreW-1:0]     square_size_o,
  output logic [lesq_pkg::PosOutW-1:0]    bottom_row_o,
  output logic [lesq_pkg::PosOutW-1:0]    right_col_o,
  output logic                            row_overflow_o
);
  import lesq_pkg::*;

  // Scoring stage
  logic              s1_valid_q;
  logic [ColW-1:0]   s1_col_q;
  logic [RowW-1:0]   s1_row_q;
  lesq_flags_t       s1_flags_q;
  logic              fwd_hit_q, fwd_hit_d;
  logic [ScoreW-1:0] fwd_data_q;

  logic [ScoreW-1:0] left_q, left_d;
  logic [ScoreW-1:0] diag_q, diag_d;
  logic [ScoreW-1:0] best_size_q, best_size_d;
  logic [RowW-1:0]   best_row_q, best_row_d;
  logic [ColW-1:0]   best_col_q, best_col_d;

  logic              out_valid_q;
  logic [ScoreW-1:0] out_size_q;
  logic [RowW-1:0]   out_row_q;
  logic [ColW-1:0]   out_col_q;
  logic              out_ovf_q;

  logic [ScoreW-1:0] ram_rdata;
  logic [ScoreW-1:0] up;
  logic [ScoreW:0]   sum;
  logic [ScoreW-1:0] score;
  logic              s1_done;
  logic              pop;
  logic              emit;
  logic              better;

  // Completion waits only when a last cell meets a full result register
  assign s1_done = s1_valid_q && (!s1_flags_q.last || !out_valid_q || out_ready_i);
  assign pop     = q_valid_i && (!s1_valid_q || s1_done);
  assign q_pop_o = pop;
  assign emit    = s1_done && s1_flags_q.last;

  lesq_ram #(
    .Width (ScoreW),
    .Depth (MaxCols)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_done),
    .waddr_i (s1_col_q),
    .wdata_i (score),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (ram_rdata)
  );

  // Score the cell; forward a write that collided with its read
  assign up  = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign sum = {1'b0, min3(up, left_q, diag_q)} + {{ScoreW{1'b0}}, 1'b1};
  always_comb begin
    if (s1_flags_q.blocked) begin
      score = '0;
    end else if (s1_flags_q.border) begin
      score = ScoreW'(1);
    end else if (sum[ScoreW]) begin
      score = ScoreMax;
    end else begin
      score = sum[ScoreW-1:0];
    end
  end

  assign better    = score > best_size_q;
  assign fwd_hit_d = s1_done && (s1_col_q == q_col_i);

  // Update running scores and the best square
  always_comb begin
    left_d      = left_q;
    diag_d      = diag_q;
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (s1_done) begin
      left_d = score;
      diag_d = up;
      if (better) begin
        best_size_d = score;
        best_row_d  = s1_row_q;
        best_col_d  = s1_col_q;
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pop) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_col_q   <= q_col_i;
      s1_row_q   <= q_row_i;
      s1_flags_q <= q_flags_i;
      fwd_hit_q  <= fwd_hit_d;
      fwd_data_q <= score;
    end
  end

  // Per-grid state; drop it when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (emit) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else begin
      left_q      <= left_d;
      diag_q      <= diag_d;
      best_size_q <= best_size_d;
      best_row_q  <= best_row_d;
      best_col_q  <= best_col_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_size_q <= best_size_d;
      out_row_q  <= best_row_d;
      out_col_q  <= best_col_d;
      out_ovf_q  <= s1_flags_q.ovf;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign square_size_o  = out_size_q;
  assign bottom_row_o   = PosOutW'(out_row_q);
  assign right_col_o    = PosOutW'(out_col_q);
  assign row_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  // A last cell always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("last cell did not load a result");

  // Best square restarts from nothing after a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (best_size_q == '0 && left_q == '0 && diag_q == '0))
    else $error("per-grid state not cleared");

  // An open cell, interior or border, scores at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_flags_q.blocked) |-> (score != '0))
    else $error("open cell scored zero");

  // The stage is never refilled while its cell is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_done) |=> ($stable(s1_col_q) && s1_valid_q))
    else $error("stalled cell overwritten");
`endif

endmodule

`default_nettype wire

/* sv/largest_empty_square_scan.sv */
// Top level of the largest empty square scan.
// Ties the front part, the queue and the back part together. Depends on
// lesq_pkg, lesq_front, lesq_queue and lesq_back.
//
//   Channel  | Direction | Handshake                   | Payload
//   ---------+-----------+-----------------------------+-----------------------------------
//   cfg      | in        | cfg_we_i                    | cfg_index_i, cfg_data_i
//   in       | in        | in_valid_i / in_ready_o     | cell_char_i, last_cell_i
//   out      | out       | out_valid_o / out_ready_i   | square_size_o, bottom_row_o,
//            |           |                             | right_col_o, row_overflow_o
//
// One cell per cycle sustained unless a waiting result stalls the back part; the
// back part's single line-buffer read and write port per cycle sets that figure.
// Reset needs no clearing pass: the line buffer is read at a column only after the
// previous row wrote it. A waiting result holds the next last cell in the back
// part; the two-entry queue then takes two more cells before the input stalls.
`default_nettype none

module largest_empty_square_scan #(
  parameter int unsigned MaxCols = lesq_pkg::MaxColsDef,
  parameter int unsigned MaxRows = lesq_pkg::MaxRowsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lesq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lesq_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lesq_pkg::CharW-1:0]      cell_char_i,
  input  logic                            last_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lesq_pkg::ScoreW-1:0]     square_size_o,
  output logic [lesq_pkg::PosOutW-1:0]    bottom_row_o,
  output logic [lesq_pkg::PosOutW-1:0]    right_col_o,
  output logic                            row_overflow_o
);
  import lesq_pkg::*;

  localparam int unsigned ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ItemW = $bits(lesq_flags_t) + RowW + ColW;

  logic              push, push_ready;
  logic [ColW-1:0]   f_col;
  logic [RowW-1:0]   f_row;
  lesq_flags_t       f_flags;
  logic [ItemW-1:0]  q_wdata, q_rdata;
  logic              q_valid, q_pop;
  logic [ColW-1:0]   b_col;
  logic [RowW-1:0]   b_row;
  lesq_flags_t       b_flags;

  lesq_front #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_char_i  (cell_char_i),
    .last_cell_i  (last_cell_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .col_o        (f_col),
    .row_o        (f_row),
    .flags_o      (f_flags)
  );

  // Pack and unpack queue entries
  assign q_wdata = {f_flags, f_row, f_col};
  assign b_col   = q_rdata[ColW-1:0];
  assign b_row   = q_rdata[ColW +: RowW];
  assign b_flags = lesq_flags_t'(q_rdata[ItemW-1 -: $bits(lesq_flags_t)]);

  lesq_queue #(
    .Width (ItemW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (push_ready),
    .data_i  (q_wdata),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  lesq_back #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_col_i        (b_col),
    .q_row_i        (b_row),
    .q_flags_i      (b_flags),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .square_size_o  (square_size_o),
    .bottom_row_o   (bottom_row_o),
    .right_col_o    (right_col_o),
    .row_overflow_o (row_overflow_o)
  );

endmodule

`default_nettype wire

/* tb/tb_largest_empty_square_scan.sv */
// Self-checking testbench for largest_empty_square_scan: streams grids of cells
// and compares every result against an in-bench scoring model.
// Depends on lesq_pkg and the largest_empty_square_scan RTL.
module tb_largest_empty_square_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import lesq_pkg::*;

  typedef struct packed {
    logic [ScoreW-1:0]  size;
    logic [PosOutW-1:0] row;
    logic [PosOutW-1:0] col;
    logic               ovf;
  } square_t;

  typedef enum logic [1:0] {ReadyAlways, ReadyCoin, ReadyRare, ReadyPeriodic} ready_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CharW-1:0]    cell_char_i;
  logic                last_cell_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ScoreW-1:0]   square_size_o;
  logic [PosOutW-1:0]  bottom_row_o;
  logic [PosOutW-1:0]  right_col_o;
  logic                row_overflow_o;

  // Scoring model state: configuration, line of scores and per-grid counters
  logic [RowWidthW-1:0] grid_width = RowWidthRst;
  logic [CharW-1:0]     block_char = ObstacleRst;
  logic [ScoreW-1:0]    line_scores [MaxColsDef];
  int unsigned          run_left = 0;
  int unsigned          run_diag = 0;
  int unsigned          scan_col = 0;
  int unsigned          scan_row = 0;
  logic                 rows_overflowed = 1'b0;
  int unsigned          top_size = 0;
  int unsigned          top_row = 0;
  int unsigned          top_col = 0;
  square_t              expected_squares [$];

  int unsigned mismatches = 0;
  int unsigned squares_seen = 0;
  int unsigned cells_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;
  int unsigned hold_cycles = 0;

  largest_empty_square_scan i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_char_i   (cell_char_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .square_size_o (square_size_o),
    .bottom_row_o  (bottom_row_o),
    .right_col_o   (right_col_o),
    .row_overflow_o(row_overflow_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Clamp the programmed width the way the block uses it
  function automatic int unsigned usable_width();
    int unsigned w;
    w = grid_width;
    if (w == 0) w = 1;
    if (w > MaxColsDef) w = MaxColsDef;
    return w;
  endfunction

  // Score one accepted cell; queue a result when it closes the grid
  task automatic predict_cell(input logic [CharW-1:0] ch, input logic last);
    int unsigned w, x, up, low, sc;
    square_t     sq;
    w = usable_width();
    if (scan_col >= w) scan_col = 0;
    x  = scan_col;
    up = line_scores[x];
    if (ch == block_char) begin
      sc = 0;
    end else if (scan_row == 0 || x == 0) begin
      sc = 1;
    end else begin
      low = up;
      if (run_left < low) low = run_left;
      if (run_diag < low) low = run_diag;
      sc = (low + 1 > ScoreMax) ? ScoreMax : low + 1;
    end
    line_scores[x] = ScoreW'(sc);
    run_diag = up;
    run_left = sc;
    // a later equal score never replaces the first one
    if (sc > top_size) begin
      top_size = sc;
      top_row  = scan_row;
      top_col  = x;
    end
    if (last) begin
      sq.size = ScoreW'(top_size);
      sq.row  = PosOutW'(top_row);
      sq.col  = PosOutW'(top_col);
      sq.ovf  = rows_overflowed;
      expected_squares.push_back(sq);
      run_left = 0;
      run_diag = 0;
      scan_col = 0;
      scan_row = 0;
      rows_overflowed = 1'b0;
      top_size = 0;
      top_row  = 0;
      top_col  = 0;
    end else if (x + 1 >= w) begin
      scan_col = 0;
      if (scan_row + 1 < MaxRowsDef) scan_row++;
      else rows_overflowed = 1'b1;
    end else begin
      scan_col = x + 1;
    end
  endtask

  // Offer one cell, idling between bursts, and hold it until the transfer
  task automatic send_cell(input logic [CharW-1:0] ch, input logic last);
    int unsigned gap;
    if (!sender_steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cell_char_i <= ch;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cell(ch, last);
    cells_sent++;
  endtask

  function automatic logic [CharW-1:0] pick_char(input int unsigned density);
    if ($urandom_range(0, 99) < density) return block_char;
    return CharW'($urandom_range(0, 255));
  endfunction

  // Stream n cells; close the grid on the final one when asked
  task automatic send_grid(input int unsigned n, input int unsigned density, input logic close);
    for (int unsigned i = 0; i < n; i++) send_cell(pick_char(density), close && (i == n - 1));
  endtask

  // Drop valid, wait for all results and let the pipeline empty
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_squares.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CfgRowWidth) grid_width = data;
    else block_char = data[CharW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] random_width();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CfgDataW'($urandom_range(MaxColsDef + 1, 2047));
    if (r == 2) return CfgDataW'(MaxColsDef);
    if (r < 5) return CfgDataW'($urandom_range(11, 64));
    return CfgDataW'($urandom_range(1, 10));
  endfunction

  // Reset settings on a short grid, then an oversized width that clamps to a
  // full row; that grid wraps once and writes every line-buffer entry
  task automatic test_full_row();
    send_grid(8, 10, 1'b1);
    write_reg(CfgRowWidth, 11'd2047);
    for (int unsigned i = 0; i < MaxColsDef + 2; i++)
      send_cell(($urandom_range(0, 9) == 0) ? ObstacleRst : CharW'($urandom_range(0, 255)),
                i == MaxColsDef + 1);
  endtask

  task automatic test_corner_cases();
    write_reg(CfgRowWidth, 11'd3);
    // every cell blocked: empty result
    send_cell(ObstacleRst, 1'b0);
    send_cell(ObstacleRst, 1'b0);
    send_cell(ObstacleRst, 1'b1);
    // bytes 0 and 255 around a blocked center; equal sizes keep the first
    send_cell(8'd0, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd0, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(ObstacleRst, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd0, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd0, 1'b1);
    // obstacle byte 0, upper data bits ignored
    write_reg(CfgObstacle, 11'h700);
    send_cell(8'd255, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd0, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd255, 1'b1);
    // obstacle byte 255, grid closed in the middle of a row
    write_reg(CfgObstacle, 11'h0FF);
    send_cell(8'd255, 1'b0);
    send_cell(8'd7, 1'b1);
  endtask

  task automatic test_width_limits();
    write_reg(CfgObstacle, 11'h2AA);
    // zero width acts as one column
    write_reg(CfgRowWidth, 11'd0);
    send_cell(8'hAA, 1'b0);
    send_cell(8'h55, 1'b1);
  endtask

  task automatic test_width_change_mid_grid();
    write_reg(CfgRowWidth, 11'd5);
    send_grid(7, 20, 1'b0);
    // column now lies past the narrower width
    write_reg(CfgRowWidth, 11'd2);
    send_grid(6, 20, 1'b0);
    write_reg(CfgRowWidth, 11'd9);
    send_grid(12, 0, 1'b1);
  endtask

  // Blocked one-cell rows up to the limit, then free two-cell rows past it
  task automatic test_row_overflow();
    write_reg(CfgRowWidth, 11'd1);
    for (int unsigned i = 0; i < MaxRowsDef - 2; i++) send_cell(block_char, 1'b0);
    write_reg(CfgRowWidth, 11'd2);
    for (int unsigned i = 0; i < 8; i++) send_cell(8'h20, i == 7);
  endtask

  // Stall results for a long stretch while short grids keep coming
  task automatic test_backpressure();
    write_reg(CfgRowWidth, 11'd1);
    @(posedge clk_i);
    hold_cycles   = 400;
    sender_steady = 1'b1;
    repeat (60) send_grid(2, 30, 1'b1);
    sender_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_grids();
    int unsigned    start_cells, start_squares, choice, density, w, n;
    logic [CharW-1:0] ob;
    start_cells   = cells_sent;
    start_squares = squares_seen;
    while (cells_sent - start_cells < 150 || squares_seen - start_squares < 20) begin
      choice  = $urandom_range(0, 99);
      density = 25 * $urandom_range(0, 4);
      if (choice < 5) begin
        case ($urandom_range(0, 9))
          0:       ob = 8'd0;
          1:       ob = 8'd255;
          default: ob = CharW'($urandom_range(0, 255));
        endcase
        write_reg(CfgObstacle, {3'($urandom_range(0, 7)), ob});
      end else if (choice < 10) begin
        write_reg(CfgRowWidth, random_width());
      end else if (choice < 14) begin
        // change width with a grid half done
        send_grid($urandom_range(1, 20), density, 1'b0);
        write_reg(CfgRowWidth, CfgDataW'($urandom_range(1, 10)));
        send_grid($urandom_range(1, 30), density, 1'b1);
      end else if (choice < 20) begin
        send_grid($urandom_range(1, 4), density, 1'b1);
      end else begin
        w = usable_width();
        if (w > 64) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * w) : $urandom_range(1, 20);
        end else begin
          n = w * $urandom_range(1, (w > 16) ? 3 : 8);
          if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        end
        send_grid(n, density, 1'b1);
      end
    end
  endtask

  // Result side: random stall patterns plus long hold-offs on request
  initial begin
    ready_mode_e mode;
    int unsigned mode_left, phase;
    mode        = ReadyAlways;
    mode_left   = 0;
    phase       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        phase++;
        case (mode)
          ReadyAlways: out_ready_i <= 1'b1;
          ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
          ReadyRare:   out_ready_i <= ($urandom_range(0, 7) == 0);
          default:     out_ready_i <= phase[2];
        endcase
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    square_t want_sq;
    if (rst_ni && out_valid_o && out_ready_i) begin
      squares_seen++;
      if (expected_squares.size() == 0) begin
        $display("%0t: result transfer with nothing expected, size %0d", $time, square_size_o);
        mismatches++;
      end else begin
        want_sq = expected_squares.pop_front();
        check_field("square_size", want_sq.size, square_size_o);
        check_field("bottom_row", want_sq.row, bottom_row_o);
        check_field("right_col", want_sq.col, right_col_o);
        check_field("row_overflow", want_sq.ovf, row_overflow_o);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_largest_empty_square_scan: FAIL");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cell_char_i = '0;
    last_cell_i = 1'b0;
    for (int unsigned i = 0; i < MaxColsDef; i++) line_scores[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_full_row();
    test_corner_cases();
    test_width_limits();
    test_width_change_mid_grid();
    test_row_overflow();
    test_backpressure();
    test_random_grids();

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_largest_empty_square_scan: PASS");
    end else begin
      $display("tb_largest_empty_square_scan: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lesq_pkg.sv
sv/lesq_ram.sv
sv/lesq_front.sv
sv/lesq_queue.sv
sv/lesq_back.sv
sv/largest_empty_square_scan.sv
tb/tb_largest_empty_square_scan.sv
